// File: hdl/dsa_pkg.sv
`default_nettype none

package dsa_pkg;

  localparam int AREA_COUNT_DEFAULT = 2;
  localparam int RING_DEPTH_DEFAULT = 8;

  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 28;
  localparam int SIZE_R_W = SIZE_W + 1;   // size after rounding up to four
  localparam int SPACE_W  = ADDR_W + 1;

  // configuration register file
  localparam int CFG_IDX_W = 3;
  localparam int CFG_COUNT = 4;

  localparam logic [ADDR_W-1:0] AREA0_START_RST = 32'h0020_0000;
  localparam logic [ADDR_W-1:0] AREA0_LIMIT_RST = 32'h0030_0000;
  localparam logic [ADDR_W-1:0] AREA1_START_RST = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] AREA1_LIMIT_RST = 32'h0610_0000;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_INIT  = 2'd2,
    ACT_LOCK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_ROOM  = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    AOP_HOLD,
    AOP_PUSH,
    AOP_POP,
    AOP_REWIND,
    AOP_LOCK
  } area_op_e;

  typedef struct packed {
    area_op_e          op;
    logic [ADDR_W-1:0] push_top;
    logic              start_we;
    logic              limit_we;
    logic [ADDR_W-1:0] cfg_data;
  } area_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cur_top;
    logic [ADDR_W-1:0] prev_top;
    logic [ADDR_W-1:0] limit;
    logic [ADDR_W-1:0] base;
  } area_stat_t;

  function automatic logic [ADDR_W-1:0] area_start_rst(input int idx);
    logic [ADDR_W-1:0] v;
    case (idx)
      0:       v = AREA0_START_RST;
      1:       v = AREA1_START_RST;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [ADDR_W-1:0] area_limit_rst(input int idx);
    logic [ADDR_W-1:0] v;
    case (idx)
      0:       v = AREA0_LIMIT_RST;
      1:       v = AREA1_LIMIT_RST;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/dsa_area.sv
`default_nettype none

module dsa_area #(
  parameter int                     RING_DEPTH  = dsa_pkg::RING_DEPTH_DEFAULT,
  parameter logic [dsa_pkg::ADDR_W-1:0] START_RESET = '0,
  parameter logic [dsa_pkg::ADDR_W-1:0] LIMIT_RESET = '0
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  dsa_pkg::area_cmd_t  cmd_i,
  output dsa_pkg::area_stat_t stat_o
);
  import dsa_pkg::*;

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(RING_DEPTH - 1);

  logic [ADDR_W-1:0] ring_q [RING_DEPTH];
  logic [PW-1:0]     pos_q;
  logic [ADDR_W-1:0] cur_q;   // mirror of ring_q[pos_q]
  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] limit_q;

  logic [PW-1:0] pos_next, pos_prev;

  assign pos_next = (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
  assign pos_prev = (pos_q == '0) ? POS_LAST : pos_q - PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s < RING_DEPTH; s++) begin
        ring_q[s] <= '0;
      end
      ring_q[0] <= START_RESET;
      pos_q     <= '0;
      cur_q     <= START_RESET;
      base_q    <= START_RESET;
      limit_q   <= LIMIT_RESET;
    end else begin
      unique case (cmd_i.op)
        AOP_PUSH: begin
          pos_q            <= pos_next;
          ring_q[pos_next] <= cmd_i.push_top;
          cur_q            <= cmd_i.push_top;
        end
        AOP_POP: begin
          pos_q <= pos_prev;
          cur_q <= ring_q[pos_prev];
        end
        AOP_REWIND: begin
          ring_q[0] <= base_q;
          pos_q     <= '0;
          cur_q     <= base_q;
        end
        AOP_LOCK: begin
          base_q <= cur_q;
        end
        AOP_HOLD: begin
        end
        default: begin
        end
      endcase
      if (cmd_i.start_we) begin
        base_q <= cmd_i.cfg_data;
      end
      if (cmd_i.limit_we) begin
        limit_q <= cmd_i.cfg_data;
      end
    end
  end

  assign stat_o.cur_top  = cur_q;
  assign stat_o.prev_top = ring_q[pos_prev];
  assign stat_o.limit    = limit_q;
  assign stat_o.base     = base_q;

endmodule

`default_nettype wire

// File: hdl/dual_area_stack_allocator.sv
`default_nettype none
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+---------------------------------------
// in      | input     | in_valid_i / in_ready_o    | action_i, area_i, size_i, address_i
// out     | output    | out_valid_o / out_ready_i  | status_o, block_address_o,
//         |           |                            | area_used_o, space_left_o
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One beat per cycle while out_ready_i is high; a beat is first held in the input register
// and its result then loads into the result register, which drives out_valid_o.
// The per-area compares, the top add and the space subtraction sit between the input
// register and the result register; area state updates on the same edge the result loads.
// Reset brings all rings to their base and positions to zero at once; no clearing pass.
// A stalled result holds the pipe: the input register keeps one more beat, then in_ready_o drops.
// cfg_ready_o is always high; writes are expected only while the block is idle.

module dual_area_stack_allocator #(
  parameter int AREA_COUNT = dsa_pkg::AREA_COUNT_DEFAULT,
  parameter int RING_DEPTH = dsa_pkg::RING_DEPTH_DEFAULT
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [1:0]                       action_i,
  input  wire                              area_i,
  input  wire  [dsa_pkg::SIZE_W-1:0]       size_i,
  input  wire  [dsa_pkg::ADDR_W-1:0]       address_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [1:0]                       status_o,
  output logic [dsa_pkg::ADDR_W-1:0]       block_address_o,
  output logic                             area_used_o,
  output logic signed [dsa_pkg::SPACE_W-1:0] space_left_o,
  // configuration write channel
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [dsa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [dsa_pkg::ADDR_W-1:0]       cfg_data_i
);
  import dsa_pkg::*;

  localparam int AW = (AREA_COUNT > 1) ? $clog2(AREA_COUNT) : 1;

  // ---------------- input register ----------------
  logic                in_vld_q;
  action_e             act_q;
  logic                area_q;
  logic [SIZE_W-1:0]   size_q;
  logic [ADDR_W-1:0]   addr_q;

  logic advance;

  // ---------------- result register ----------------
  logic                out_vld_q;
  status_e             status_q;
  logic [ADDR_W-1:0]   block_q;
  logic                used_q;
  logic [SPACE_W-1:0]  space_q;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      act_q  <= action_e'(action_i);
      area_q <= area_i;
      size_q <= size_i;
      addr_q <= address_i;
    end
  end

  // ---------------- per-area storage ----------------
  area_cmd_t  cmd  [AREA_COUNT];
  area_stat_t stat [AREA_COUNT];

  // ---------------- request decode ----------------
  logic [AW-1:0]       req;
  logic [SIZE_R_W-1:0] size_r;
  logic [AREA_COUNT-1:0] fits;
  logic [AREA_COUNT-1:0] hits;
  logic [AW-1:0]       alloc_sel;
  logic                alloc_ok;
  logic [AW-1:0]       free_sel;
  logic                free_ok;
  logic [ADDR_W-1:0]   next_cur [AREA_COUNT];
  logic [ADDR_W-1:0]   alloc_top;

  // area index folds into the configured count
  assign req    = (AREA_COUNT == 1) ? '0 : AW'(area_q);
  assign size_r = ({1'b0, size_q} + SIZE_R_W'(3)) & ~SIZE_R_W'(3);

  for (genvar a = 0; a < AREA_COUNT; a++) begin : g_fit
    logic [SPACE_W-1:0] room;
    assign room    = {1'b0, stat[a].limit} - {1'b0, stat[a].cur_top};
    // strictly greater; a top at the limit gives zero room and a top past it negative room
    assign fits[a] = $signed(room) > $signed({{(SPACE_W-SIZE_R_W){1'b0}}, size_r});
    assign hits[a] = (stat[a].prev_top == addr_q);
  end

  // first fitting area starting at the preferred one, wrapping
  always_comb begin
    int idx;
    alloc_sel = '0;
    alloc_ok  = 1'b0;
    for (int k = AREA_COUNT - 1; k >= 0; k--) begin
      idx = int'(req) + k;
      if (idx >= AREA_COUNT) begin
        idx = idx - AREA_COUNT;
      end
      if (fits[AW'(idx)]) begin
        alloc_sel = AW'(idx);
        alloc_ok  = 1'b1;
      end
    end
  end

  // lowest-index area whose previous top matches
  always_comb begin
    free_sel = '0;
    free_ok  = 1'b0;
    for (int a = AREA_COUNT - 1; a >= 0; a--) begin
      if (hits[a]) begin
        free_sel = AW'(a);
        free_ok  = 1'b1;
      end
    end
  end

  assign alloc_top = stat[alloc_sel].cur_top;

  for (genvar a = 0; a < AREA_COUNT; a++) begin : g_area
    logic cfg_hit;
    assign cfg_hit = cfg_valid_i && (cfg_index_i < CFG_IDX_W'(CFG_COUNT)) &&
                     ({cfg_index_i[CFG_IDX_W-1:1], 1'b0} == CFG_IDX_W'(2 * a));

    always_comb begin
      cmd[a].op       = AOP_HOLD;
      cmd[a].push_top = stat[a].cur_top + ADDR_W'(size_r);
      // index bit zero picks limit over start
      cmd[a].start_we = cfg_hit && !cfg_index_i[0];
      cmd[a].limit_we = cfg_hit && cfg_index_i[0];
      cmd[a].cfg_data = cfg_data_i;
      next_cur[a]     = stat[a].cur_top;
      unique case (act_q)
        ACT_ALLOC: begin
          if (alloc_ok && alloc_sel == AW'(a)) begin
            cmd[a].op   = AOP_PUSH;
            next_cur[a] = cmd[a].push_top;
          end
        end
        ACT_FREE: begin
          if (free_ok && free_sel == AW'(a)) begin
            cmd[a].op   = AOP_POP;
            next_cur[a] = stat[a].prev_top;
          end
        end
        ACT_INIT: begin
          cmd[a].op = AOP_REWIND;
        end
        ACT_LOCK: begin
          cmd[a].op = AOP_LOCK;
        end
        default: begin
        end
      endcase
      if (!advance) begin
        cmd[a].op = AOP_HOLD;
      end
    end

    dsa_area #(
      .RING_DEPTH  (RING_DEPTH),
      .START_RESET (area_start_rst(a)),
      .LIMIT_RESET (area_limit_rst(a))
    ) u_area (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[a]),
      .stat_o (stat[a])
    );
  end

  // rewind puts every area back on its locked base, seen here as the next top
  logic [ADDR_W-1:0] req_next_top;

  assign req_next_top = (act_q == ACT_INIT) ? stat[req].base : next_cur[req];

  // ---------------- result ----------------
  status_e            status_d;
  logic [ADDR_W-1:0]  block_d;
  logic               used_d;
  logic [SPACE_W-1:0] space_d;

  always_comb begin
    status_d = STATUS_OK;
    block_d  = '0;
    used_d   = 1'b0;
    unique case (act_q) inside
      ACT_ALLOC: begin
        if (alloc_ok) begin
          block_d = alloc_top;
          used_d  = alloc_sel[0];
        end else begin
          status_d = STATUS_NO_ROOM;
        end
      end
      ACT_FREE: begin
        if (free_ok) begin
          used_d = free_sel[0];
        end else begin
          status_d = STATUS_BAD_FREE;
        end
      end
      ACT_INIT, ACT_LOCK: begin
      end
      default: begin
      end
    endcase
    space_d = {1'b0, stat[req].limit} - {1'b0, req_next_top};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      block_q  <= block_d;
      used_q   <= used_d;
      space_q  <= space_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign block_address_o = block_q;
  assign area_used_o     = used_q;
  assign space_left_o    = $signed(space_q);
  assign cfg_ready_o     = 1'b1;

endmodule

`default_nettype wire
